/* rtl/bls_pkg.sv */
// Shared types and constants for the bounded LIFO stack.
`default_nettype none

package bls_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int WORD_BITS       = 32;
    localparam int CMD_BITS        = 3;
    localparam int CNT_BITS        = 4;
    localparam int STATUS_BITS     = 2;
    localparam int CAP_RESET       = 5;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEPTH = 2'd3
    } status_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [WORD_BITS-1:0] data_word;
        logic [CNT_BITS-1:0]  depth_from_top;
    } cmd_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]   read_word;
        logic [STATUS_BITS-1:0] status_code;
        logic [CNT_BITS-1:0]    entry_count;
        logic                   full_flag;
        logic                   empty_flag;
    } rsp_item_t;

endpackage

`default_nettype wire

/* rtl/bls_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module bls_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/bls_ctrl.sv */
// Command decode, fill count, capacity register and result register of the stack.
`default_nettype none

module bls_ctrl
    import bls_pkg::*;
#(
    parameter int  STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CNT_BITS-1:0]  cfg_wdata,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire cmd_item_t            cmd,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_item_t                 rsp,
    output logic                      mem_we,
    output logic                      mem_re,
    output logic      [ADDR_W-1:0]    mem_addr,
    output logic      [WORD_BITS-1:0] mem_wdata,
    input  wire logic [WORD_BITS-1:0] mem_rdata
);

    // The count port is four bits wide, so the usable limit never exceeds its maximum.
    localparam int CNT_MAX     = (1 << CNT_BITS) - 1;
    localparam int DEPTH_CLAMP = (STACK_DEPTH > CNT_MAX) ? CNT_MAX : STACK_DEPTH;
    localparam int LIM_RST_INT = (CAP_RESET > DEPTH_CLAMP) ? DEPTH_CLAMP : CAP_RESET;
    localparam logic [CNT_BITS-1:0] DEPTH_LIM = CNT_BITS'(DEPTH_CLAMP);
    localparam logic [CNT_BITS-1:0] LIM_RESET = CNT_BITS'(LIM_RST_INT);
    localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CNT_BITS-1:0]    limit_reg, limit_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   peek_ok_reg, peek_ok_next;
    logic [STATUS_BITS-1:0] status_reg;
    logic [CNT_BITS-1:0]    rcount_reg;
    logic                   full_reg, empty_reg;

    logic                   accept;
    logic                   full_now;
    logic                   empty_now;
    logic                   bad_depth;
    status_t                status;
    logic [CNT_BITS-1:0]    slot;
    logic [ADDR_W+CNT_BITS-1:0] slot_wide;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign full_now  = (count_reg >= limit_reg);
    assign empty_now = (count_reg == '0);
    assign bad_depth = (cmd.depth_from_top == '0) || (cmd.depth_from_top > count_reg);

    // Map the count-based slot onto the RAM address width.
    assign slot_wide = {{ADDR_W{1'b0}}, slot};
    assign mem_addr  = slot_wide[ADDR_W-1:0];
    assign mem_wdata = cmd.data_word;

    // Clamp the capacity to 1..DEPTH_LIM as it is written.
    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                limit_next = CNT_ONE;
            end
            else if (cfg_wdata > DEPTH_LIM)
            begin
                limit_next = DEPTH_LIM;
            end
            else
            begin
                limit_next = cfg_wdata;
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        status       = ST_OK;
        slot         = count_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        peek_ok_next = 1'b0;
        case (cmd.command)
            CMD_PUSH:
            begin
                if (full_now)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mem_we     = accept;
                    count_next = count_reg + CNT_ONE;
                end
            end
            CMD_POP:
            begin
                if (empty_now)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                end
            end
            CMD_PEEK, CMD_WRITE:
            begin
                slot = count_reg - cmd.depth_from_top;
                if (empty_now)
                begin
                    status = ST_EMPTY;
                end
                else if (bad_depth)
                begin
                    status = ST_DEPTH;
                end
                else if (cmd.command == CMD_PEEK)
                begin
                    mem_re       = accept;
                    peek_ok_next = 1'b1;
                end
                else
                begin
                    mem_we = accept;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= LIM_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the result fields until the next transfer is accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            peek_ok_reg <= peek_ok_next;
            status_reg  <= status;
            rcount_reg  <= count_next;
            full_reg    <= (count_next >= limit_reg);
            empty_reg   <= (count_next == '0);
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp.read_word   = peek_ok_reg ? mem_rdata : '0;
    assign rsp.status_code = status_reg;
    assign rsp.entry_count = rcount_reg;
    assign rsp.full_flag   = full_reg;
    assign rsp.empty_flag  = empty_reg;

endmodule

`default_nettype wire

/* rtl/bounded_lifo_stack.sv */
// Bounded LIFO stack: word RAM plus command controller.
//
// Commands arrive on the cmd channel (cmd_valid/cmd_stall, payload cmd) and
// each one yields exactly one response on the rsp channel (rsp_valid/rsp_stall,
// payload rsp): the peeked word, a status code, the count and the flags.
// A command is accepted when cmd_valid is high and cmd_stall is low; its
// response is valid on the following cycle.
// Throughput is one command per cycle while the receiver takes responses;
// the single-port word RAM, with its registered read, serves the at most
// one access that each command needs.
// When the receiver stalls, the response register holds its payload and
// cmd_stall rises until that response is transferred.
// Reset empties the stack, drops any pending response and sets the capacity
// to five entries (RAM words are not cleared). Only while the block is idle
// must the user write the capacity via cfg_we/cfg_wdata; the block does not
// enforce it. Zero acts as one; values beyond the RAM depth act as the depth.
`default_nettype none

module bounded_lifo_stack
    import bls_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CNT_BITS-1:0] cfg_wdata,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire cmd_item_t           cmd,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output rsp_item_t                rsp
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    bls_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bls_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded LIFO stack: command stimulus and response check.

module tb;
    import bls_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    // Mirror of the stack: predicts the response of every accepted command.
    class stack_mirror;
        logic [WORD_BITS-1:0] words [STACK_DEPTH_DEF];
        int unsigned          fill;
        logic [CNT_BITS-1:0]  capacity;
        rsp_item_t            due_rsp [$];
        int                   faults;

        function new();
            fill     = 0;
            capacity = CNT_BITS'(CAP_RESET);
            faults   = 0;
        endfunction

        function int unsigned eff_limit();
            int unsigned lim;
            lim = capacity;
            if (lim < 1)
                lim = 1;
            if (lim > STACK_DEPTH_DEF)
                lim = STACK_DEPTH_DEF;
            return lim;
        endfunction

        function void set_capacity(logic [CNT_BITS-1:0] value);
            capacity = value;
        endfunction

        function void take_command(cmd_item_t c);
            rsp_item_t   r;
            status_t     st;
            int unsigned lim;
            int unsigned slot;
            lim         = eff_limit();
            st          = ST_OK;
            r.read_word = '0;
            case (c.command)
                CMD_PUSH:
                begin
                    if (fill >= lim)
                        st = ST_FULL;
                    else
                    begin
                        words[fill] = c.data_word;
                        fill++;
                    end
                end
                CMD_POP:
                begin
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                        fill--;
                end
                CMD_PEEK, CMD_WRITE:
                begin
                    if (fill == 0)
                        st = ST_EMPTY;
                    else if (c.depth_from_top < 1 || c.depth_from_top > fill)
                        st = ST_DEPTH;
                    else
                    begin
                        slot = fill - c.depth_from_top;
                        if (c.command == CMD_PEEK)
                            r.read_word = words[slot];
                        else
                            words[slot] = c.data_word;
                    end
                end
                CMD_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            r.status_code = st;
            r.entry_count = CNT_BITS'(fill);
            r.full_flag   = (fill >= lim);
            r.empty_flag  = (fill == 0);
            due_rsp.push_back(r);
        endfunction

        function void match_response(rsp_item_t got);
            rsp_item_t want;
            if (due_rsp.size() == 0)
            begin
                $error("response with no command outstanding: %h", got);
                faults++;
                return;
            end
            want = due_rsp.pop_front();
            if (got.read_word !== want.read_word)
            begin
                $error("read_word: expected %h, actual %h", want.read_word, got.read_word);
                faults++;
            end
            if (got.status_code !== want.status_code)
            begin
                $error("status_code: expected %0d, actual %0d",
                       want.status_code, got.status_code);
                faults++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                faults++;
            end
            if (got.full_flag !== want.full_flag)
            begin
                $error("full_flag: expected %b, actual %b", want.full_flag, got.full_flag);
                faults++;
            end
            if (got.empty_flag !== want.empty_flag)
            begin
                $error("empty_flag: expected %b, actual %b", want.empty_flag, got.empty_flag);
                faults++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    cmd_item_t           cmd       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_item_t           rsp;

    stack_mirror mirror;
    bit          gaps_on     = 1'b1;
    int          idle_cycles = 0;

    bounded_lifo_stack DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic cmd_item_t make_item(logic [CMD_BITS-1:0] op,
                                            logic [WORD_BITS-1:0] word,
                                            logic [CNT_BITS-1:0] depth);
        cmd_item_t c;
        c.command        = op;
        c.data_word      = word;
        c.depth_from_top = depth;
        return c;
    endfunction

    function automatic cmd_item_t random_item(int push_weight);
        cmd_item_t c;
        int        r;
        c.data_word = $urandom();
        if (mirror.fill > 0 && $urandom_range(0, 99) < 85)
            c.depth_from_top = CNT_BITS'($urandom_range(1, mirror.fill));
        else
            c.depth_from_top = CNT_BITS'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < push_weight)
            c.command = CMD_PUSH;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                c.command = CMD_POP;
            else if (r < 68)
                c.command = CMD_PEEK;
            else if (r < 92)
                c.command = CMD_WRITE;
            else if (r < 96)
                c.command = CMD_CLEAR;
            else
                c.command = CMD_BITS'($urandom_range(5, 7));
        end
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_command(input cmd_item_t c);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       = c;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        mirror.take_command(c);
        @(negedge clk);
    endtask

    // Drop valid and wait until every response has been transferred.
    task automatic drain();
        cmd_valid = 1'b0;
        do
            @(negedge clk);
        while (mirror.due_rsp.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_BITS-1:0] value);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        mirror.set_capacity(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Response monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                mirror.match_response(rsp);
            if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Receiver back-pressure: open stretches broken by stalls of random length.
    initial
    begin : rsp_stall_gen
        int open_len;
        int stall_len;
        @(posedge rst_n);
        forever
        begin
            open_len  = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            stall_len = gaps_on ? pick_gap() : 0;
            repeat (open_len) @(negedge clk);
            if (stall_len > 0)
            begin
                rsp_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
                rsp_stall = 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        logic [CNT_BITS-1:0] caps [9];
        int                  push_weight;
        caps   = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd9, 4'd2, 4'd7, 4'd5};
        mirror = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty stack refuses pop, peek and overwrite.
        send_command(make_item(CMD_POP, 32'h0, 4'd1));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd1));
        send_command(make_item(CMD_WRITE, 32'h1234_5678, 4'd1));
        send_command(make_item(CMD_PUSH, 32'hFFFF_FFFF, 4'd0));
        send_command(make_item(CMD_PUSH, 32'h0000_0000, 4'd15));
        send_command(make_item(CMD_PUSH, 32'hA5A5_5A5A, 4'd8));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd1));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd3));
        // Bad depth on either side of the valid range.
        send_command(make_item(CMD_PEEK, 32'h0, 4'd0));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd4));
        send_command(make_item(CMD_WRITE, 32'hDEAD_BEEF, 4'd2));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd2));
        send_command(make_item(CMD_PUSH, 32'h0F0F_F0F0, 4'd0));
        send_command(make_item(CMD_PUSH, 32'h8000_0001, 4'd0));
        // Full at the reset capacity.
        send_command(make_item(CMD_PUSH, 32'h7FFF_FFFE, 4'd0));
        send_command(make_item(3'd5, 32'hFFFF_FFFF, 4'd15));
        send_command(make_item(3'd7, 32'h0, 4'd0));
        // Capacity below the count: full, yet pop and peek still work.
        write_capacity(4'd2);
        send_command(make_item(CMD_PUSH, 32'h1111_1111, 4'd0));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd5));
        send_command(make_item(CMD_PEEK, 32'h0, 4'd15));
        send_command(make_item(CMD_POP, 32'h0, 4'd0));
        send_command(make_item(CMD_WRITE, 32'h2222_2222, 4'd4));
        send_command(make_item(CMD_CLEAR, 32'h0, 4'd0));
        send_command(make_item(CMD_POP, 32'h0, 4'd0));
        send_command(make_item(3'd6, 32'h0, 4'd0));

        for (int phase = 0; phase < 9; phase++)
        begin
            write_capacity(caps[phase]);
            gaps_on = (phase % 3 != 1);
            for (int i = 0; i < 100; i++)
            begin
                // Alternate fill and drain bias so the count sweeps its range.
                push_weight = ((i / 12) % 2) ? 25 : 60;
                send_command(random_item(push_weight));
            end
        end

        gaps_on = 1'b1;
        drain();
        if (mirror.faults == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
